FILE: rtl/sacache_pkg.sv
// Package: shared constants, config and status types for the cache hit/miss model.
`timescale 1ns / 1ps
package sacache_pkg;

    localparam int NUM_SETS_DEF      = 64;
    localparam int NUM_WAYS_DEF      = 4;
    localparam int COUNTER_WIDTH_DEF = 16;

    localparam int ADDR_W      = 32;
    localparam int SETNUM_W    = 6;
    localparam int WAYOUT_W    = 2;
    localparam int HITTOT_W    = 32;
    localparam int CYCTOT_W    = 48;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_SET_BITS = 6;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_LRU  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_BITS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_CYCLES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_PEN    = 3'd6;

    typedef struct packed {
        logic       policy_lru;
        logic [2:0] ways_in_use;
        logic [2:0] set_index_bits;
        logic [3:0] block_offset_bits;
        logic [5:0] address_bits;
        logic [7:0] hit_cycles;
        logic [9:0] miss_penalty_cycles;
    } cfg_t;

    // Per-access outcome handed from the line engine to the top-level result output.
    typedef struct packed {
        logic                was_hit;
        logic [SETNUM_W-1:0] set_number;
        logic [ADDR_W-1:0]   tag_value;
        logic [WAYOUT_W-1:0] way_used;
        logic                replaced_valid;
    } access_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } eng_state_t;

endpackage

FILE: rtl/sacache_cfg.sv
// Configuration register file.
`timescale 1ns / 1ps
module sacache_cfg
    import sacache_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy_lru          <= 1'b1;
            cfg_reg.ways_in_use         <= 3'd4;
            cfg_reg.set_index_bits      <= 3'd6;
            cfg_reg.block_offset_bits   <= 4'd4;
            cfg_reg.address_bits        <= 6'd32;
            cfg_reg.hit_cycles          <= 8'd1;
            cfg_reg.miss_penalty_cycles <= 10'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY_LRU:  cfg_reg.policy_lru          <= cfg_data[0];
                REG_WAYS_IN_USE: cfg_reg.ways_in_use         <= cfg_data[2:0];
                REG_SET_BITS:    cfg_reg.set_index_bits      <= cfg_data[2:0];
                REG_OFFSET_BITS: cfg_reg.block_offset_bits   <= cfg_data[3:0];
                REG_ADDR_BITS:   cfg_reg.address_bits        <= cfg_data[5:0];
                REG_HIT_CYCLES:  cfg_reg.hit_cycles          <= cfg_data[7:0];
                REG_MISS_PEN:    cfg_reg.miss_penalty_cycles <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/sacache_stats.sv
// Saturating hit, miss and cycle totals.
`timescale 1ns / 1ps
module sacache_stats
    import sacache_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upd,
    input  logic                was_hit,
    input  cfg_t                cfg,
    output logic [HITTOT_W-1:0] hit_total,
    output logic [HITTOT_W-1:0] miss_total,
    output logic [CYCTOT_W-1:0] cycle_total
);

    logic [HITTOT_W-1:0] hits_reg, misses_reg;
    logic [CYCTOT_W-1:0] cyc_reg;
    logic [10:0]         charge;
    logic [CYCTOT_W:0]   cyc_sum;

    assign charge  = was_hit ? {3'd0, cfg.hit_cycles}
                             : {3'd0, cfg.hit_cycles} + {1'b0, cfg.miss_penalty_cycles};
    assign cyc_sum = {1'b0, cyc_reg} + {{(CYCTOT_W-10){1'b0}}, charge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg   <= '0;
            misses_reg <= '0;
            cyc_reg    <= '0;
        end
        else if (upd)
        begin
            if (was_hit && !(&hits_reg))
                hits_reg <= hits_reg + 1'b1;
            if (!was_hit && !(&misses_reg))
                misses_reg <= misses_reg + 1'b1;
            cyc_reg <= cyc_sum[CYCTOT_W] ? '1 : cyc_sum[CYCTOT_W-1:0];
        end
    end

    assign hit_total   = hits_reg;
    assign miss_total  = misses_reg;
    assign cycle_total = cyc_reg;

endmodule

FILE: rtl/sacache_engine.sv
// Line engine: set memory read, tag compare, victim choice and write-back.
`timescale 1ns / 1ps
module sacache_engine
    import sacache_pkg::*;
#(
    parameter int NUM_SETS      = NUM_SETS_DEF,
    parameter int NUM_WAYS      = NUM_WAYS_DEF,
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ADDR_W-1:0] in_addr,
    output logic              res_valid,
    input  logic              res_ready,
    output access_t           res,
    output logic              stat_upd,
    output logic              stat_hit
);

    localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WCNT_W = $clog2(NUM_WAYS + 1);
    localparam int ROW_W  = NUM_WAYS * (1 + ADDR_W + COUNTER_WIDTH);
    localparam int VIC_SWEEP = NUM_SETS;

    typedef struct packed {
        logic                     valid;
        logic [ADDR_W-1:0]        tag;
        logic [COUNTER_WIDTH-1:0] cnt;
    } line_t;

    // One row per set, all ways side by side; clearing pass resets valid and count.
    line_t [NUM_WAYS-1:0] mem [NUM_SETS];
    line_t [NUM_WAYS-1:0] rd_reg;
    line_t [NUM_WAYS-1:0] wr_row;

    eng_state_t state_reg, state_next;
    logic [SET_AW:0]     clr_reg;
    logic                clearing;
    logic [SET_AW-1:0]   row_reg;
    logic [SETNUM_W-1:0] setn_reg;
    logic [ADDR_W-1:0]   tag_reg;
    access_t             res_reg, res_next;

    logic [ADDR_W-1:0]   amask, addr_m;
    logic [5:0]          ab;
    logic [2:0]          sb;
    logic [SETNUM_W-1:0] setn;
    logic [ADDR_W-1:0]   tag;
    logic [4:0]          tsh;
    logic [WCNT_W-1:0]   w;

    logic                hit, found;
    logic [WAY_W-1:0]    way, hway, fway, vway;
    logic [COUNTER_WIDTH-1:0] best;

    assign clearing = ~clr_reg[SET_AW];

    // Address split.
    always_comb
    begin
        ab     = (cfg.address_bits > 6'd32) ? 6'd32 : cfg.address_bits;
        sb     = (cfg.set_index_bits > 3'd6) ? 3'd6 : cfg.set_index_bits;
        amask  = (ab == 6'd32) ? '1 : ((ADDR_W'(1) << ab[4:0]) - 1'b1);
        addr_m = in_addr & amask;
        setn   = SETNUM_W'((addr_m >> cfg.block_offset_bits)
                 & ((ADDR_W'(1) << sb) - 1'b1));
        tag    = ({1'b0, cfg.block_offset_bits} + {2'b0, sb} > 5'd31) ? '0
                 : addr_m >> ({1'b0, cfg.block_offset_bits} + {2'b0, sb});
        tsh    = '0;
        if (cfg.ways_in_use == 3'd0)
            w = WCNT_W'(1);
        else if ({29'd0, cfg.ways_in_use} > 32'(NUM_WAYS))
            w = WCNT_W'(NUM_WAYS);
        else
            w = WCNT_W'(cfg.ways_in_use);
    end

    // Search and victim choice on the registered row.
    always_comb
    begin
        hit = 1'b0; hway = '0; found = 1'b0; fway = '0;
        vway = '0; best = rd_reg[0].cnt;
        for (int k = NUM_WAYS - 1; k >= 0; k--)
        begin
            if (WCNT_W'(k) < w && rd_reg[k].valid && rd_reg[k].tag == tag_reg)
            begin
                hit = 1'b1; hway = WAY_W'(k);
            end
            if (WCNT_W'(k) < w && !rd_reg[k].valid)
            begin
                found = 1'b1; fway = WAY_W'(k);
            end
        end
        for (int k = 1; k < NUM_WAYS; k++)
        begin
            if (WCNT_W'(k) < w &&
                (cfg.policy_lru ? (rd_reg[k].cnt > best) : (rd_reg[k].cnt < best)))
            begin
                best = rd_reg[k].cnt; vway = WAY_W'(k);
            end
        end
        way = hit ? hway : (found ? fway : vway);

        wr_row = rd_reg;
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            if (WAY_W'(k) == way)
            begin
                if (!hit)
                begin
                    wr_row[k].valid = 1'b1;
                    wr_row[k].tag   = tag_reg;
                end
                if (cfg.policy_lru)
                    wr_row[k].cnt = '0;
                else if (hit)
                    wr_row[k].cnt = (&rd_reg[k].cnt) ? rd_reg[k].cnt : rd_reg[k].cnt + 1'b1;
                else
                    wr_row[k].cnt = COUNTER_WIDTH'(1);
            end
            else if (cfg.policy_lru && WCNT_W'(k) < w)
                wr_row[k].cnt = (&rd_reg[k].cnt) ? rd_reg[k].cnt : rd_reg[k].cnt + 1'b1;
        end

        res_next.was_hit        = hit;
        res_next.set_number     = setn_reg;
        res_next.tag_value      = tag_reg;
        res_next.way_used       = WAYOUT_W'(way);
        res_next.replaced_valid = !hit && !found;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid && !clearing) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_OUT;
            ST_OUT:    if (res_ready) state_next = (in_valid ? ST_LOOKUP : ST_IDLE);
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = !clearing && (state_reg == ST_IDLE || (state_reg == ST_OUT && res_ready));
        res_valid = (state_reg == ST_OUT);
        stat_upd  = (state_reg == ST_LOOKUP);
        stat_hit  = hit;
        res       = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            row_reg  <= SET_AW'(setn % VIC_SWEEP);
            setn_reg <= setn;
            tag_reg  <= tag | ADDR_W'(tsh);
            rd_reg   <= mem[SET_AW'(setn % VIC_SWEEP)];
        end
        if (state_reg == ST_LOOKUP)
            res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
            mem[clr_reg[SET_AW-1:0]] <= '0;
        else if (state_reg == ST_LOOKUP)
            mem[row_reg] <= wr_row;
    end

endmodule

FILE: rtl/set_assoc_cache_hit_miss_model.sv
// Top level: set-associative cache hit/miss model with LRU/LFU replacement.
`timescale 1ns / 1ps
// An accepted item has its set row read, then is compared and written back in ST_LOOKUP;
// its result is valid in ST_OUT. Items do not overlap, due to the read-modify-write of the row.
// A new item is accepted in the same cycle its predecessor's result is taken.
// After reset a clearing pass zeroes valid bits and counters;
// no item is accepted during it. Config writes are taken at any time.
module set_assoc_cache_hit_miss_model
    import sacache_pkg::*;
#(
    parameter int NUM_SETS      = NUM_SETS_DEF,
    parameter int NUM_WAYS      = NUM_WAYS_DEF,
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // address[31:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // was_hit[0], set_number[6:1], tag_value[38:7], way_used[40:39],
    // replaced_valid[41], hit_total[73:42], miss_total[105:74], cycle_total[153:106]
    output logic [159:0]          m_tdata
);

    cfg_t    cfg;
    access_t res;
    logic    stat_upd;
    logic    stat_hit;
    logic [HITTOT_W-1:0] hit_total, miss_total;
    logic [CYCTOT_W-1:0] cycle_total;

    sacache_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    sacache_engine #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_eng (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_addr(s_tdata),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res), .stat_upd(stat_upd),
        .stat_hit(stat_hit)
    );

    // Totals update in the compare cycle, so they are stable while the result waits.
    sacache_stats u_stats (
        .clk(clk), .rst_n(rst_n), .upd(stat_upd), .was_hit(stat_hit),
        .cfg(cfg), .hit_total(hit_total), .miss_total(miss_total),
        .cycle_total(cycle_total)
    );

    assign m_tdata = {6'd0, cycle_total, miss_total, hit_total, res.replaced_valid,
                      res.way_used, res.tag_value, res.set_number, res.was_hit};

endmodule
